[rtl/nnse_pkg.sv]
// ---------------------------------------------------------------------------
// nnse_pkg
// Shared types, constants and the doublet stacking-energy ROM for the
// nearest-neighbour stack energy block.
// ---------------------------------------------------------------------------
package nnse_pkg;

  localparam int unsigned MAX_PAIRS_DEFAULT = 64;
  localparam int unsigned MID_DEPTH         = 4;
  localparam int unsigned OUT_DEPTH         = 2;

  localparam int unsigned BASE_W   = 3;
  localparam int unsigned ENERGY_W = 10;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned TALLY_W  = 6;
  localparam int unsigned SCALED_W = 20;
  localparam int unsigned RT_W     = 16;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned CFG_W    = 16;

  localparam logic signed [ENERGY_W-1:0] MISS_PENALTY   = 10'sd200;
  localparam logic                       TEMPLATE_DNA_RESET = 1'b1;
  localparam logic                       PARTNER_DNA_RESET  = 1'b0;
  localparam logic [RT_W-1:0]            INVERSE_RT_RESET   = 16'd6924;

  typedef enum logic [1:0] {
    REG_TEMPLATE_IS_DNA = 2'd0,
    REG_PARTNER_IS_DNA  = 2'd1,
    REG_INVERSE_RT      = 2'd2
  } cfg_reg_t;

  // One classified base pair handed from the front to the back.
  typedef struct packed {
    logic                       last;
    logic                       doublet;
    logic                       miss;
    logic signed [ENERGY_W-1:0] energy;
  } doublet_t;

  // One finished duplex result.
  typedef struct packed {
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SUM_W-1:0]    raw;
    logic [TALLY_W-1:0]         count;
  } result_t;

  typedef struct packed {
    logic                       found;
    logic signed [ENERGY_W-1:0] energy;
  } rom_hit_t;

  // Key: strand combination, previous partner, partner, previous template,
  // template; two bits each. Where a key repeats, the first entry wins.
  function automatic rom_hit_t stack_rom(input logic [9:0] key);
    rom_hit_t hit;
    hit.found = 1'b1;
    case (key)
      {2'd0,2'd0,2'd0,2'd3,2'd3}: hit.energy = -10'sd93;
      {2'd0,2'd3,2'd3,2'd0,2'd0}: hit.energy = -10'sd93;
      {2'd0,2'd0,2'd3,2'd3,2'd0}: hit.energy = -10'sd110;
      {2'd0,2'd3,2'd0,2'd0,2'd3}: hit.energy = -10'sd133;
      {2'd0,2'd1,2'd3,2'd2,2'd0}: hit.energy = -10'sd208;
      {2'd0,2'd0,2'd2,2'd3,2'd1}: hit.energy = -10'sd208;
      {2'd0,2'd1,2'd0,2'd2,2'd3}: hit.energy = -10'sd211;
      {2'd0,2'd3,2'd2,2'd0,2'd1}: hit.energy = -10'sd211;
      {2'd0,2'd2,2'd3,2'd1,2'd0}: hit.energy = -10'sd224;
      {2'd0,2'd0,2'd1,2'd3,2'd2}: hit.energy = -10'sd224;
      {2'd0,2'd2,2'd0,2'd1,2'd3}: hit.energy = -10'sd235;
      {2'd0,2'd3,2'd1,2'd0,2'd2}: hit.energy = -10'sd235;
      {2'd0,2'd1,2'd2,2'd2,2'd1}: hit.energy = -10'sd236;
      {2'd0,2'd2,2'd2,2'd1,2'd1}: hit.energy = -10'sd326;
      {2'd0,2'd1,2'd1,2'd2,2'd2}: hit.energy = -10'sd326;
      {2'd0,2'd2,2'd1,2'd1,2'd2}: hit.energy = -10'sd342;
      {2'd0,2'd0,2'd2,2'd3,2'd3}: hit.energy = -10'sd55;
      {2'd0,2'd3,2'd3,2'd2,2'd0}: hit.energy = -10'sd55;
      {2'd0,2'd0,2'd3,2'd3,2'd2}: hit.energy = -10'sd136;
      {2'd0,2'd2,2'd3,2'd3,2'd0}: hit.energy = -10'sd136;
      {2'd0,2'd1,2'd2,2'd2,2'd3}: hit.energy = -10'sd141;
      {2'd0,2'd3,2'd2,2'd2,2'd1}: hit.energy = -10'sd141;
      {2'd0,2'd1,2'd3,2'd2,2'd2}: hit.energy = -10'sd211;
      {2'd0,2'd2,2'd2,2'd3,2'd1}: hit.energy = -10'sd211;
      {2'd0,2'd2,2'd2,2'd1,2'd3}: hit.energy = -10'sd153;
      {2'd0,2'd3,2'd1,2'd2,2'd2}: hit.energy = -10'sd153;
      {2'd0,2'd2,2'd3,2'd1,2'd2}: hit.energy = -10'sd251;
      {2'd0,2'd2,2'd1,2'd3,2'd2}: hit.energy = -10'sd251;
      {2'd0,2'd2,2'd0,2'd3,2'd3}: hit.energy = -10'sd127;
      {2'd0,2'd3,2'd3,2'd0,2'd2}: hit.energy = -10'sd127;
      {2'd0,2'd2,2'd2,2'd3,2'd3}: hit.energy = -10'sd50;
      {2'd0,2'd3,2'd3,2'd2,2'd2}: hit.energy = -10'sd50;
      {2'd0,2'd2,2'd3,2'd3,2'd2}: hit.energy = 10'sd129;
      {2'd0,2'd3,2'd2,2'd0,2'd3}: hit.energy = -10'sd100;
      {2'd0,2'd3,2'd0,2'd2,2'd3}: hit.energy = -10'sd100;
      {2'd0,2'd3,2'd2,2'd2,2'd3}: hit.energy = 10'sd30;
      {2'd2,2'd0,2'd0,2'd3,2'd3}: hit.energy = -10'sd100;
      {2'd2,2'd0,2'd1,2'd3,2'd2}: hit.energy = -10'sd210;
      {2'd2,2'd0,2'd2,2'd3,2'd1}: hit.energy = -10'sd180;
      {2'd2,2'd0,2'd3,2'd3,2'd0}: hit.energy = -10'sd90;
      {2'd2,2'd1,2'd0,2'd2,2'd3}: hit.energy = -10'sd90;
      {2'd2,2'd1,2'd1,2'd2,2'd2}: hit.energy = -10'sd210;
      {2'd2,2'd1,2'd2,2'd2,2'd1}: hit.energy = -10'sd170;
      {2'd2,2'd1,2'd3,2'd2,2'd0}: hit.energy = -10'sd90;
      {2'd2,2'd2,2'd0,2'd1,2'd3}: hit.energy = -10'sd130;
      {2'd2,2'd2,2'd1,2'd1,2'd2}: hit.energy = -10'sd270;
      {2'd2,2'd2,2'd2,2'd1,2'd1}: hit.energy = -10'sd290;
      {2'd2,2'd2,2'd3,2'd1,2'd0}: hit.energy = -10'sd110;
      {2'd2,2'd3,2'd0,2'd0,2'd3}: hit.energy = -10'sd60;
      {2'd2,2'd3,2'd1,2'd0,2'd2}: hit.energy = -10'sd150;
      {2'd2,2'd3,2'd2,2'd0,2'd1}: hit.energy = -10'sd160;
      {2'd2,2'd3,2'd3,2'd0,2'd0}: hit.energy = -10'sd20;
      {2'd1,2'd3,2'd3,2'd0,2'd0}: hit.energy = -10'sd100;
      {2'd1,2'd2,2'd3,2'd1,2'd0}: hit.energy = -10'sd210;
      {2'd1,2'd1,2'd3,2'd2,2'd0}: hit.energy = -10'sd180;
      {2'd1,2'd0,2'd3,2'd3,2'd0}: hit.energy = -10'sd90;
      {2'd1,2'd3,2'd2,2'd0,2'd1}: hit.energy = -10'sd90;
      {2'd1,2'd2,2'd2,2'd1,2'd1}: hit.energy = -10'sd210;
      {2'd1,2'd1,2'd2,2'd2,2'd1}: hit.energy = -10'sd170;
      {2'd1,2'd0,2'd2,2'd3,2'd1}: hit.energy = -10'sd90;
      {2'd1,2'd3,2'd1,2'd0,2'd2}: hit.energy = -10'sd130;
      {2'd1,2'd2,2'd1,2'd1,2'd2}: hit.energy = -10'sd270;
      {2'd1,2'd1,2'd1,2'd2,2'd2}: hit.energy = -10'sd290;
      {2'd1,2'd0,2'd1,2'd3,2'd2}: hit.energy = -10'sd110;
      {2'd1,2'd3,2'd0,2'd0,2'd3}: hit.energy = -10'sd60;
      {2'd1,2'd2,2'd0,2'd1,2'd3}: hit.energy = -10'sd150;
      {2'd1,2'd1,2'd0,2'd2,2'd3}: hit.energy = -10'sd160;
      {2'd1,2'd0,2'd0,2'd3,2'd3}: hit.energy = -10'sd20;
      {2'd3,2'd0,2'd0,2'd3,2'd3}: hit.energy = -10'sd100;
      {2'd3,2'd3,2'd3,2'd0,2'd0}: hit.energy = -10'sd100;
      {2'd3,2'd0,2'd3,2'd3,2'd0}: hit.energy = -10'sd88;
      {2'd3,2'd3,2'd0,2'd0,2'd3}: hit.energy = -10'sd58;
      {2'd3,2'd1,2'd3,2'd2,2'd0}: hit.energy = -10'sd128;
      {2'd3,2'd0,2'd2,2'd3,2'd1}: hit.energy = -10'sd128;
      {2'd3,2'd1,2'd0,2'd2,2'd3}: hit.energy = -10'sd145;
      {2'd3,2'd3,2'd2,2'd0,2'd1}: hit.energy = -10'sd145;
      {2'd3,2'd2,2'd3,2'd1,2'd0}: hit.energy = -10'sd144;
      {2'd3,2'd0,2'd1,2'd3,2'd2}: hit.energy = -10'sd144;
      {2'd3,2'd2,2'd0,2'd1,2'd3}: hit.energy = -10'sd130;
      {2'd3,2'd3,2'd1,2'd0,2'd2}: hit.energy = -10'sd130;
      {2'd3,2'd1,2'd2,2'd2,2'd1}: hit.energy = -10'sd217;
      {2'd3,2'd2,2'd2,2'd1,2'd1}: hit.energy = -10'sd184;
      {2'd3,2'd1,2'd1,2'd2,2'd2}: hit.energy = -10'sd184;
      {2'd3,2'd2,2'd1,2'd1,2'd2}: hit.energy = -10'sd224;
      default: begin
        hit.found  = 1'b0;
        hit.energy = MISS_PENALTY;
      end
    endcase
    return hit;
  endfunction

endpackage

[rtl/nnse_fifo.sv]
// ---------------------------------------------------------------------------
// nnse_fifo
// Small synchronous queue with first-word fall-through read.
// ---------------------------------------------------------------------------
module nnse_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/nnse_front.sv]
// ---------------------------------------------------------------------------
// nnse_front
// Accepts base pairs, forms doublets with the previous pair and looks up
// their stacking energy.
// ---------------------------------------------------------------------------
module nnse_front #(
  parameter int unsigned MAX_PAIRS = nnse_pkg::MAX_PAIRS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [nnse_pkg::BASE_W-1:0]   template_base,
  input  logic [nnse_pkg::BASE_W-1:0]   partner_base,
  input  logic                          strand_end,
  input  logic                          template_is_dna,
  input  logic                          partner_is_dna,
  output nnse_pkg::doublet_t            entry
);

  localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);

  logic [nnse_pkg::BASE_W-1:0] previous_template;
  logic [nnse_pkg::BASE_W-1:0] previous_partner;
  logic                        have_previous;
  logic [CNT_W-1:0]            pairs_seen;
  logic                        room;
  logic                        all_valid;
  logic [9:0]                  key;
  nnse_pkg::rom_hit_t          hit;

  assign room      = (pairs_seen < CNT_W'(MAX_PAIRS));
  assign all_valid = !template_base[2] && !partner_base[2]
                     && !previous_template[2] && !previous_partner[2];
  assign key = {template_is_dna, partner_is_dna, previous_partner[1:0],
                partner_base[1:0], previous_template[1:0], template_base[1:0]};
  assign hit = nnse_pkg::stack_rom(key);

  always_comb begin
    entry.last    = strand_end;
    entry.doublet = room && have_previous;
    entry.miss    = !(all_valid && hit.found);
    entry.energy  = (all_valid && hit.found) ? hit.energy : nnse_pkg::MISS_PENALTY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_template <= '0;
      previous_partner  <= '0;
      have_previous     <= 1'b0;
      pairs_seen        <= '0;
    end else if (take) begin
      if (strand_end) begin
        previous_template <= '0;
        previous_partner  <= '0;
        have_previous     <= 1'b0;
        pairs_seen        <= '0;
      end else if (room) begin
        previous_template <= template_base;
        previous_partner  <= partner_base;
        have_previous     <= 1'b1;
        pairs_seen        <= pairs_seen + 1'b1;
      end
    end
  end

  a_pairs_bound: assert property (@(posedge clk) disable iff (rst)
    pairs_seen <= CNT_W'(MAX_PAIRS))
    else $error("pair counter beyond limit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && strand_end) |=> (!have_previous && pairs_seen == '0))
    else $error("duplex state not cleared after end mark");

endmodule

[rtl/nnse_back.sv]
// ---------------------------------------------------------------------------
// nnse_back
// Sums doublet energies with saturation, then scales the finished sum by
// the reciprocal-RT register.
// ---------------------------------------------------------------------------
module nnse_back (
  input  logic                          clk,
  input  logic                          rst,
  input  nnse_pkg::doublet_t            entry,
  input  logic                          entry_ready,
  output logic                          entry_take,
  input  logic [nnse_pkg::RT_W-1:0]     inverse_rt,
  input  logic                          out_full,
  output logic                          out_push,
  output nnse_pkg::result_t             result
);

  localparam int unsigned SUM_W   = nnse_pkg::SUM_W;
  localparam int unsigned TALLY_W = nnse_pkg::TALLY_W;
  localparam int unsigned PROD_W  = SUM_W + nnse_pkg::RT_W + 1;

  logic signed [SUM_W-1:0]   energy_sum;
  logic [TALLY_W-1:0]        missing_tally;
  logic signed [SUM_W-1:0]   fin_sum;
  logic [TALLY_W-1:0]        fin_tally;
  logic                      fin_valid;
  logic                      fin_free;
  logic signed [SUM_W:0]     wide_sum;
  logic signed [SUM_W-1:0]   sum_next;
  logic [TALLY_W-1:0]        tally_next;
  logic signed [PROD_W-1:0]  product;

  always_comb begin
    wide_sum = {energy_sum[SUM_W-1], energy_sum} + (SUM_W + 1)'(entry.energy);
    if (!entry.doublet) begin
      sum_next = energy_sum;
    end else if (wide_sum > (SUM_W + 1)'(signed'({1'b0, {(SUM_W-1){1'b1}}}))) begin
      sum_next = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (wide_sum < $signed({2'b11, {(SUM_W-1){1'b0}}})) begin
      sum_next = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_next = wide_sum[SUM_W-1:0];
    end
    if (entry.doublet && entry.miss && (missing_tally != '1)) begin
      tally_next = missing_tally + 1'b1;
    end else begin
      tally_next = missing_tally;
    end
  end

  assign fin_free   = !fin_valid || !out_full;
  assign entry_take = entry_ready && (!entry.last || fin_free);
  assign out_push   = fin_valid && !out_full;

  assign product = fin_sum * $signed({1'b0, inverse_rt});

  always_comb begin
    result.scaled = product[nnse_pkg::FRAC_W +: nnse_pkg::SCALED_W];
    result.raw    = fin_sum;
    result.count  = fin_tally;
  end

  always_ff @(posedge clk) begin
    if (entry_take && entry.last) begin
      fin_sum   <= sum_next;
      fin_tally <= tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum    <= '0;
      missing_tally <= '0;
      fin_valid     <= 1'b0;
    end else begin
      if (entry_take) begin
        if (entry.last) begin
          energy_sum    <= '0;
          missing_tally <= '0;
        end else begin
          energy_sum    <= sum_next;
          missing_tally <= tally_next;
        end
      end
      if (entry_take && entry.last) begin
        fin_valid <= 1'b1;
      end else if (out_push) begin
        fin_valid <= 1'b0;
      end
    end
  end

  a_fin_loaded: assert property (@(posedge clk) disable iff (rst)
    (entry_take && entry.last) |=> fin_valid)
    else $error("finished sum not held after end of duplex");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (entry_take && entry.last && fin_valid) |-> out_push)
    else $error("pending result overwritten");

endmodule

[rtl/nearest_neighbor_stack_energy.sv]
// ---------------------------------------------------------------------------
// nearest_neighbor_stack_energy
// Nearest-neighbour stacking free energy of a duplex streamed one base pair
// per transaction.
// ---------------------------------------------------------------------------
// Input side: a queue-style write port. A transaction (template_base,
// partner_base, strand_end) is taken on a clock edge with push high and full
// low. One base pair can be taken every cycle while full stays low.
// Result side: a queue-style read port. While empty is low the oldest result
// (energy_scaled, energy_raw, missing_count) is on the ports, and it is
// removed on a clock edge with pop high. Only a pair with strand_end set
// produces a result; all other pairs only update the running sum.
// Path: the doublet lookup of an end-marked pair is written into the middle
// queue, accumulated into the finished-sum register when the back takes it,
// and the product of that register is then written into the result queue.
// Throughput is one pair per cycle while full is low, set by the single ROM
// lookup in the front and the single saturating add in the back.
// Configuration: write_enable, write_index, write_data; index 0 template
// strand is DNA, 1 partner strand is DNA, 2 reciprocal RT in Q4.12. Writes
// beyond index 2 are ignored. Write only while the block is idle.
// Reset (rst, synchronous) empties both queues, clears the running duplex
// and restores the register defaults. When the reader stalls, results back
// up in the result queue, then the middle queue fills and full rises; no
// transaction is ever dropped.
// ---------------------------------------------------------------------------
module nearest_neighbor_stack_energy #(
  parameter int unsigned MAX_PAIRS = nnse_pkg::MAX_PAIRS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input queue port
  input  logic                                  push,
  output logic                                  full,
  input  logic [nnse_pkg::BASE_W-1:0]           template_base,
  input  logic [nnse_pkg::BASE_W-1:0]           partner_base,
  input  logic                                  strand_end,
  // Result queue port
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [nnse_pkg::SCALED_W-1:0]  energy_scaled,
  output logic signed [nnse_pkg::SUM_W-1:0]     energy_raw,
  output logic [nnse_pkg::TALLY_W-1:0]          missing_count,
  // Configuration write port
  input  logic                                  write_enable,
  input  logic [1:0]                            write_index,
  input  logic [nnse_pkg::CFG_W-1:0]            write_data
);

  // Configuration registers.
  logic                          template_is_dna;
  logic                          partner_is_dna;
  logic [nnse_pkg::RT_W-1:0]     inverse_rt;

  // Front to back.
  logic                          take;
  logic                          mid_full;
  logic                          mid_empty;
  logic                          mid_take;
  nnse_pkg::doublet_t            front_entry;
  nnse_pkg::doublet_t            back_entry;

  // Back to result queue.
  logic                          out_full;
  logic                          out_push;
  nnse_pkg::result_t             back_result;
  nnse_pkg::result_t             head_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      template_is_dna <= nnse_pkg::TEMPLATE_DNA_RESET;
      partner_is_dna  <= nnse_pkg::PARTNER_DNA_RESET;
      inverse_rt      <= nnse_pkg::INVERSE_RT_RESET;
    end else if (write_enable) begin
      case (nnse_pkg::cfg_reg_t'(write_index))
        nnse_pkg::REG_TEMPLATE_IS_DNA: template_is_dna <= write_data[0];
        nnse_pkg::REG_PARTNER_IS_DNA:  partner_is_dna  <= write_data[0];
        nnse_pkg::REG_INVERSE_RT:      inverse_rt      <= write_data[nnse_pkg::RT_W-1:0];
        default: ;
      endcase
    end
  end

  // The input side is full exactly when the middle queue is.
  assign full = mid_full;
  assign take = push && !mid_full;

  nnse_front #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .template_base   (template_base),
    .partner_base    (partner_base),
    .strand_end      (strand_end),
    .template_is_dna (template_is_dna),
    .partner_is_dna  (partner_is_dna),
    .entry           (front_entry)
  );

  // Short queue that lets the front keep taking pairs while the back waits
  // for room in the result queue.
  nnse_fifo #(
    .WIDTH ($bits(nnse_pkg::doublet_t)),
    .DEPTH (nnse_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_data (front_entry),
    .rd_en   (mid_take),
    .rd_data (back_entry),
    .empty   (mid_empty),
    .full    (mid_full)
  );

  nnse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (back_entry),
    .entry_ready (!mid_empty),
    .entry_take  (mid_take),
    .inverse_rt  (inverse_rt),
    .out_full    (out_full),
    .out_push    (out_push),
    .result      (back_result)
  );

  // Result queue; its storage is also the register after the multiplier.
  nnse_fifo #(
    .WIDTH ($bits(nnse_pkg::result_t)),
    .DEPTH (nnse_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (back_result),
    .rd_en   (pop),
    .rd_data (head_result),
    .empty   (empty),
    .full    (out_full)
  );

  assign energy_scaled = head_result.scaled;
  assign energy_raw    = head_result.raw;
  assign missing_count = head_result.count;

endmodule

[test/nearest_neighbor_stack_energy_tb.sv]
// ---------------------------------------------------------------------------
// nearest_neighbor_stack_energy_tb
// Self-checking testbench for the nearest-neighbour stack energy block. A
// short table of directed base pairs is followed by phases of random
// duplexes under changing strand types and reciprocal-RT settings. Every
// duplex energy returned is compared with the directed table or a local predictor.
// ---------------------------------------------------------------------------
module nearest_neighbor_stack_energy_tb;
  import nnse_pkg::*;

  localparam int CYCLE        = 20;
  localparam int MAX_PAIRS    = MAX_PAIRS_DEFAULT;
  localparam int RANDOM_PAIRS = 1150;
  localparam int PHASE_PAIRS  = 140;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int MISS_ENERGY  = 200;

  // Base codes on both strands; T and U share a code.
  localparam logic [BASE_W-1:0] BASE_A   = 3'd0;
  localparam logic [BASE_W-1:0] BASE_C   = 3'd1;
  localparam logic [BASE_W-1:0] BASE_G   = 3'd2;
  localparam logic [BASE_W-1:0] BASE_T   = 3'd3;
  localparam logic [BASE_W-1:0] BASE_N   = 3'd4;
  localparam logic [BASE_W-1:0] BASE_MAX = 3'd7;

  // Register index with no register behind it; a write there must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Results that can be read straight off the behaviour: a duplex with no
  // doublet scores zero, and a single missing doublet under the reset
  // reciprocal RT scores 200 raw, floor(200 * 6924 / 4096) = 338 scaled.
  localparam result_t ZERO_ENERGY = '0;
  localparam result_t ONE_MISS    = '{scaled: 20'sd338, raw: 16'sd200, count: 6'd1};

  typedef struct packed {
    logic [BASE_W-1:0] tb;
    logic [BASE_W-1:0] pb;
    logic              is_end;
    logic              typed;
    result_t           res;
  } pair_row_t;

  localparam int N_DIRECTED = 20;

  // Directed pairs, all under the reset setting (DNA template, RNA partner).
  // Rows with typed set carry their expected result; the rest are predicted.
  pair_row_t directed_rows [N_DIRECTED] = '{
    '{BASE_A,   BASE_A,   1'b1, 1'b1, ZERO_ENERGY},  // lone pair, no doublet
    '{BASE_MAX, BASE_MAX, 1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_MAX, BASE_MAX, 1'b1, 1'b1, ONE_MISS},     // top codes never match
    '{BASE_T,   BASE_A,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_T,   BASE_A,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_G,   BASE_C,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_C,   BASE_G,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_A,   BASE_T,   1'b1, 1'b0, ZERO_ENERGY},
    '{BASE_N,   BASE_A,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_A,   BASE_N,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_C,   BASE_C,   1'b0, 1'b0, ZERO_ENERGY},  // mismatched pair
    '{BASE_A,   BASE_MAX, 1'b1, 1'b0, ZERO_ENERGY},
    '{BASE_MAX, BASE_A,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_A,   BASE_MAX, 1'b1, 1'b1, ONE_MISS},
    '{BASE_T,   BASE_A,   1'b1, 1'b1, ZERO_ENERGY},
    '{BASE_G,   BASE_C,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_G,   BASE_C,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_G,   BASE_C,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_G,   BASE_C,   1'b0, 1'b0, ZERO_ENERGY},
    '{BASE_G,   BASE_C,   1'b1, 1'b0, ZERO_ENERGY}
  };

  // Every input of the block starts at a known value.
  logic                       clk;
  logic                       rst           = 1'b1;
  logic                       push          = 1'b0;
  logic                       full;
  logic [BASE_W-1:0]          template_base = '0;
  logic [BASE_W-1:0]          partner_base  = '0;
  logic                       strand_end    = 1'b0;
  logic                       empty;
  logic                       pop           = 1'b0;
  logic signed [SCALED_W-1:0] energy_scaled;
  logic signed [SUM_W-1:0]    energy_raw;
  logic [TALLY_W-1:0]         missing_count;
  logic                       write_enable  = 1'b0;
  logic [1:0]                 write_index   = '0;
  logic [CFG_W-1:0]           write_data    = '0;

  nearest_neighbor_stack_energy dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .template_base (template_base),
    .partner_base  (partner_base),
    .strand_end    (strand_end),
    .empty         (empty),
    .pop           (pop),
    .energy_scaled (energy_scaled),
    .energy_raw    (energy_raw),
    .missing_count (missing_count),
    .write_enable  (write_enable),
    .write_index   (write_index),
    .write_data    (write_data)
  );

  // -------------------------------------------------------------------------
  // Predictor state: its own copy of the registers and of the running duplex.
  // -------------------------------------------------------------------------
  bit                cfg_tdna    = TEMPLATE_DNA_RESET;
  bit                cfg_pdna    = PARTNER_DNA_RESET;
  int                cfg_rt      = INVERSE_RT_RESET;
  logic [BASE_W-1:0] last_t      = '0;
  logic [BASE_W-1:0] last_p      = '0;
  bit                have_last   = 1'b0;
  int                acc_sum     = 0;
  int                acc_missing = 0;
  int                pairs_taken = 0;

  // Stacking energies indexed by the doublet key: strand combination,
  // previous partner, partner, previous template, template (two bits each).
  bit rom_known  [0:1023];
  int rom_energy [0:1023];

  result_t pending_energies [$];

  int  pairs_sent      = 0;
  int  random_pairs    = 0;
  int  duplexes_scored = 0;
  int  mismatches      = 0;
  int  phases_run      = 0;
  bit  stall_wanted    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CYCLE / 2) clk = ~clk;
  end

  // A hard stop well beyond the slowest legal run.
  initial begin
    #(CYCLE * 400000);
    $display("Timeout: the block stopped making progress.");
    $display("*** FAILED ***");
    $finish;
  end

  // Where a key appears twice the first value is kept.
  function automatic void rom_put(input int c, input int n0, input int n1,
                                  input int g0, input int g1, input int e);
    int key;
    key = (c << 8) | (n0 << 6) | (n1 << 4) | (g0 << 2) | g1;
    if (!rom_known[key]) begin
      rom_known[key]  = 1'b1;
      rom_energy[key] = e;
    end
  endfunction

  initial begin : stack_energy_table
    foreach (rom_known[k]) rom_known[k] = 1'b0;
    // RNA template, RNA partner.
    rom_put(0,0,0,3,3, -93); rom_put(0,3,3,0,0, -93); rom_put(0,0,3,3,0,-110);
    rom_put(0,3,0,0,3,-133); rom_put(0,1,3,2,0,-208); rom_put(0,0,2,3,1,-208);
    rom_put(0,1,0,2,3,-211); rom_put(0,3,2,0,1,-211); rom_put(0,2,3,1,0,-224);
    rom_put(0,0,1,3,2,-224); rom_put(0,2,0,1,3,-235); rom_put(0,3,1,0,2,-235);
    rom_put(0,1,2,2,1,-236); rom_put(0,2,2,1,1,-326); rom_put(0,1,1,2,2,-326);
    rom_put(0,2,1,1,2,-342); rom_put(0,0,2,3,3, -55); rom_put(0,3,3,2,0, -55);
    rom_put(0,0,3,3,2,-136); rom_put(0,2,3,3,0,-136); rom_put(0,1,2,2,3,-141);
    rom_put(0,3,2,2,1,-141); rom_put(0,1,3,2,2,-211); rom_put(0,2,2,3,1,-211);
    rom_put(0,2,2,1,3,-153); rom_put(0,3,1,2,2,-153); rom_put(0,2,3,1,2,-251);
    rom_put(0,2,1,3,2,-251); rom_put(0,2,0,3,3,-127); rom_put(0,3,3,0,2,-127);
    rom_put(0,2,2,3,3, -50); rom_put(0,3,3,2,2, -50); rom_put(0,2,3,3,2, 129);
    rom_put(0,3,2,0,3,-100); rom_put(0,3,0,2,3,-100); rom_put(0,3,2,2,3,  30);
    // DNA template, RNA partner.
    rom_put(2,0,0,3,3,-100); rom_put(2,0,1,3,2,-210); rom_put(2,0,2,3,1,-180);
    rom_put(2,0,3,3,0, -90); rom_put(2,1,0,2,3, -90); rom_put(2,1,1,2,2,-210);
    rom_put(2,1,2,2,1,-170); rom_put(2,1,3,2,0, -90); rom_put(2,2,0,1,3,-130);
    rom_put(2,2,1,1,2,-270); rom_put(2,2,2,1,1,-290); rom_put(2,2,3,1,0,-110);
    rom_put(2,3,0,0,3, -60); rom_put(2,3,1,0,2,-150); rom_put(2,3,2,0,1,-160);
    rom_put(2,3,3,0,0, -20);
    // RNA template, DNA partner.
    rom_put(1,3,3,0,0,-100); rom_put(1,2,3,1,0,-210); rom_put(1,1,3,2,0,-180);
    rom_put(1,0,3,3,0, -90); rom_put(1,3,2,0,1, -90); rom_put(1,2,2,1,1,-210);
    rom_put(1,1,2,2,1,-170); rom_put(1,0,2,3,1, -90); rom_put(1,3,1,0,2,-130);
    rom_put(1,2,1,1,2,-270); rom_put(1,1,1,2,2,-290); rom_put(1,0,1,3,2,-110);
    rom_put(1,3,0,0,3, -60); rom_put(1,2,0,1,3,-150); rom_put(1,1,0,2,3,-160);
    rom_put(1,0,0,3,3, -20);
    // DNA template, DNA partner.
    rom_put(3,0,0,3,3,-100); rom_put(3,3,3,0,0,-100); rom_put(3,0,3,3,0, -88);
    rom_put(3,3,0,0,3, -58); rom_put(3,1,3,2,0,-128); rom_put(3,0,2,3,1,-128);
    rom_put(3,1,0,2,3,-145); rom_put(3,3,2,0,1,-145); rom_put(3,2,3,1,0,-144);
    rom_put(3,0,1,3,2,-144); rom_put(3,2,0,1,3,-130); rom_put(3,3,1,0,2,-130);
    rom_put(3,1,2,2,1,-217); rom_put(3,2,2,1,1,-184); rom_put(3,1,1,2,2,-184);
    rom_put(3,2,1,1,2,-224);
  end

  // Folds one accepted base pair into the running duplex. On an end-marked
  // pair it hands back the duplex energy and clears the running state. Once
  // a duplex has reached its pair limit, further pairs change nothing.
  function automatic void accumulate_pair(input logic [BASE_W-1:0] tb,
                                          input logic [BASE_W-1:0] pb,
                                          input logic is_end,
                                          output bit emits, output result_t res);
    int         e;
    logic [9:0] key;
    longint     prod;
    emits = 1'b0;
    res   = '0;
    if (pairs_taken < MAX_PAIRS) begin
      if (have_last) begin
        e   = MISS_ENERGY;
        key = {cfg_tdna, cfg_pdna, last_p[1:0], pb[1:0], last_t[1:0], tb[1:0]};
        // Any base coded above T makes the doublet a miss.
        if (tb < 4 && pb < 4 && last_t < 4 && last_p < 4 && rom_known[key])
          e = rom_energy[key];
        else if (acc_missing < 63)
          acc_missing++;
        acc_sum += e;
        if (acc_sum > 32767)  acc_sum = 32767;
        if (acc_sum < -32768) acc_sum = -32768;
      end
      last_t      = tb;
      last_p      = pb;
      have_last   = 1'b1;
      pairs_taken++;
    end
    if (is_end) begin
      // Floor division by 4096 is an arithmetic shift of the product.
      prod       = longint'(acc_sum) * longint'(cfg_rt);
      res.scaled = SCALED_W'(prod >>> FRAC_W);
      res.raw    = SUM_W'(acc_sum);
      res.count  = TALLY_W'(acc_missing);
      emits      = 1'b1;
      last_t      = '0;
      last_p      = '0;
      have_last   = 1'b0;
      acc_sum     = 0;
      acc_missing = 0;
      pairs_taken = 0;
    end
  endfunction

  // Offers one base pair after a random gap and waits until the block takes
  // it. The task is entered just after the clock rises; push stays high between
  // transactions that follow one another with no gap, so that it is never lowered
  // and raised in the same time step.
  task automatic send_pair(input logic [BASE_W-1:0] tb, input logic [BASE_W-1:0] pb,
                           input logic is_end, input int max_gap,
                           input bit typed, input result_t typed_res);
    int      gap;
    bit      emits;
    result_t res;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    template_base <= tb;
    partner_base  <= pb;
    strand_end    <= is_end;
    // The value of full read straight after the edge is the one the block
    // saw at that edge.
    do @(posedge clk); while (full);
    accumulate_pair(tb, pb, is_end, emits, res);
    if (emits)
      pending_energies.insert(pending_energies.size(), typed ? typed_res : res);
    pairs_sent++;
  endtask

  // One random duplex. Most pairs are Watson-Crick complements so that the
  // lookups hit the table; a share of bases is noise over the full code
  // range, and now and then a duplex is cut short or runs past the limit.
  task automatic send_duplex(input int max_gap, input int short_len);
    int                len;
    int                pick;
    logic [BASE_W-1:0] tb;
    logic [BASE_W-1:0] pb;
    logic              is_end;
    if (short_len > 0) begin
      len = $urandom_range(1, short_len);
    end else begin
      pick = $urandom_range(0, 39);
      if (pick == 0)      len = 1;
      else if (pick == 1) len = $urandom_range(MAX_PAIRS - 4, MAX_PAIRS + 16);
      else                len = $urandom_range(2, 12);
    end
    for (int i = 0; i < len; i++) begin
      tb = BASE_W'($urandom_range(0, 3));
      pb = BASE_T - tb;
      if ($urandom_range(0, 7) == 0) tb = BASE_W'($urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0) pb = BASE_W'($urandom_range(0, 7));
      is_end = (i == len - 1) || ($urandom_range(0, 63) == 0);
      send_pair(tb, pb, is_end, max_gap, 1'b0, ZERO_ENERGY);
      random_pairs++;
    end
  endtask

  // Stops offering and waits, within a bound, until every expected duplex
  // energy has come back, then lets the pipeline run dry.
  task automatic settle();
    int waited;
    push   <= 1'b0;
    waited = 0;
    while (pending_energies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers in consecutive cycles, optionally followed by
  // a write to the spare index. The single-bit registers get random upper
  // bits, which the block must drop.
  task automatic apply_config(input bit tdna, input bit pdna, input logic [RT_W-1:0] rt,
                              input bit poke_spare);
    write_enable <= 1'b1;
    write_index  <= REG_TEMPLATE_IS_DNA;
    write_data   <= {15'($urandom), tdna};
    @(posedge clk);
    cfg_tdna     = tdna;
    write_index  <= REG_PARTNER_IS_DNA;
    write_data   <= {15'($urandom), pdna};
    @(posedge clk);
    cfg_pdna     = pdna;
    write_index  <= REG_INVERSE_RT;
    write_data   <= rt;
    @(posedge clk);
    cfg_rt       = rt;
    if (poke_spare) begin
      write_index <= REG_SPARE;
      write_data  <= 16'($urandom);
      @(posedge clk);
    end
    write_enable <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Result side: pops with random stalls, with calm stretches of no stall,
  // and one long hold-off on request from the stimulus side. Each popped
  // transaction is checked against the oldest expected duplex energy.
  // -------------------------------------------------------------------------
  initial begin : result_side
    int      stall;
    int      calm_left;
    result_t want;
    calm_left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (calm_left > 0) begin
        stall = 0;
        calm_left--;
      end else begin
        stall = $urandom_range(0, 9);
        if ($urandom_range(0, 15) == 0) calm_left = 20;
      end
      if (stall_wanted) begin
        // Hold off long enough for both internal queues to fill and for
        // full to push back on the stimulus side.
        stall_wanted = 1'b0;
        stall        = LONG_HOLD;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      duplexes_scored++;
      if (pending_energies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: scaled %0d raw %0d missing %0d",
                   energy_scaled, energy_raw, missing_count);
      end else begin
        want = pending_energies.pop_front();
        if (energy_scaled !== want.scaled || energy_raw !== want.raw ||
            missing_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected scaled %0d raw %0d missing %0d, got %0d %0d %0d",
                     want.scaled, want.raw, want.count,
                     energy_scaled, energy_raw, missing_count);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus side: reset, the directed table under the reset setting, then
  // phases of random duplexes. Each phase starts from an idle block with a
  // fresh setting; the strand combination walks through all four cases and
  // the reciprocal RT visits zero, all ones and its reset value. The second
  // phase opens with a burst of short duplexes offered without gaps while
  // the result side holds off, so that the block fills and stalls its input.
  // -------------------------------------------------------------------------
  initial begin : stimulus_side
    int              max_gap;
    int              phase_start;
    logic [RT_W-1:0] rt;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++)
      send_pair(directed_rows[r].tb, directed_rows[r].pb, directed_rows[r].is_end, 9,
                directed_rows[r].typed, directed_rows[r].res);

    while (random_pairs < RANDOM_PAIRS) begin
      // The stimulus side waits here until every expected result is back.
      settle();
      case (phases_run % 5)
        0:       rt = '0;
        1:       rt = '1;
        2:       rt = INVERSE_RT_RESET;
        default: rt = RT_W'($urandom);
      endcase
      apply_config(phases_run[1], phases_run[0], rt, (phases_run % 3) == 0);
      max_gap = ((phases_run % 3) == 2) ? 0 : 9;
      if (phases_run == 1) begin
        stall_wanted = 1'b1;
        repeat (20) send_duplex(0, 3);
      end
      phase_start = random_pairs;
      while (random_pairs - phase_start < PHASE_PAIRS) send_duplex(max_gap, 0);
      phases_run++;
    end
    settle();

    // Anything still expected at this point never arrived.
    mismatches += pending_energies.size();
    $display("Run covered %0d base pair transactions over %0d register settings,",
             pairs_sent, phases_run + 1);
    $display("with %0d duplex energies returned and %0d mismatches.",
             duplexes_scored, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/nnse_pkg.sv
rtl/nnse_fifo.sv
rtl/nnse_front.sv
rtl/nnse_back.sv
rtl/nearest_neighbor_stack_energy.sv
test/nearest_neighbor_stack_energy_tb.sv
